// ----- rtl/kmm_pkg.sv -----
// Shared types and constants for the keyboard-to-mouse mapper.
// Holds the beat structs, the mapper state struct, key codes and report kinds.
// No dependencies.
package kmm_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_CODE_W   = 10;
    localparam int KEY_ACTION_W = 2;
    localparam int SPEED_W      = 7;
    localparam int REPEAT_W     = 4;
    localparam int WHEEL_STEP_W = 3;

    // Motion speed cap and reset values.
    localparam int                   MAX_MOTION_SPEED_DEF = 64;
    localparam logic [SPEED_W-1:0]   START_SPEED          = 7'd2;
    localparam logic [REPEAT_W-1:0]  START_REPEATS        = 4'd1;
    localparam logic [REPEAT_W-1:0]  REPEATS_STEP         = 4'd2;
    localparam logic [WHEEL_STEP_W-1:0] WHEEL_STEP_RESET  = 3'd5;
    localparam logic [WHEEL_STEP_W-1:0] WHEEL_STEP_MIN    = 3'd1;

    // Key codes that the mapper reacts to.
    localparam logic [KEY_CODE_W-1:0] KC_U     = 10'd22;
    localparam logic [KEY_CODE_W-1:0] KC_P     = 10'd25;
    localparam logic [KEY_CODE_W-1:0] KC_LCTRL = 10'd29;
    localparam logic [KEY_CODE_W-1:0] KC_F     = 10'd33;
    localparam logic [KEY_CODE_W-1:0] KC_V     = 10'd47;
    localparam logic [KEY_CODE_W-1:0] KC_B     = 10'd48;
    localparam logic [KEY_CODE_W-1:0] KC_N     = 10'd49;
    localparam logic [KEY_CODE_W-1:0] KC_M     = 10'd50;
    localparam logic [KEY_CODE_W-1:0] KC_LALT  = 10'd56;
    localparam logic [KEY_CODE_W-1:0] KC_SPACE = 10'd57;
    localparam logic [KEY_CODE_W-1:0] KC_CAPS  = 10'd58;

    // Key values.
    localparam logic [KEY_ACTION_W-1:0] KV_RELEASE = 2'd0;
    localparam logic [KEY_ACTION_W-1:0] KV_PRESS   = 2'd1;
    localparam logic [KEY_ACTION_W-1:0] KV_REPEAT  = 2'd2;

    // Kind of report carried by a result beat.
    typedef enum logic [2:0] {
        RK_NONE   = 3'd0,
        RK_MOTION = 3'd1,
        RK_WHEEL  = 3'd2,
        RK_LEFT   = 3'd3,
        RK_RIGHT  = 3'd4
    } t_report_kind;

    // One key event beat.
    typedef struct packed {
        logic                    is_key_event;
        logic [KEY_CODE_W-1:0]   key_code;
        logic [KEY_ACTION_W-1:0] key_action;
    } t_kmm_in;

    // One mouse report beat.
    typedef struct packed {
        logic                    swallowed;
        t_report_kind            report_kind;
        logic signed [7:0]       delta_x;
        logic signed [7:0]       delta_y;
        logic signed [3:0]       wheel_delta;
        logic [KEY_ACTION_W-1:0] button_level;
    } t_kmm_out;

    // Modifier, lock and speed-ramp state.
    typedef struct packed {
        logic                ctrl_held;
        logic                alt_held;
        logic                speed_lock;
        logic [SPEED_W-1:0]  motion_speed;
        logic [REPEAT_W-1:0] repeat_count;
        logic [REPEAT_W-1:0] repeats_needed;
    } t_kmm_state;

    localparam t_kmm_state KMM_STATE_RESET = '{
        ctrl_held:      1'b0,
        alt_held:       1'b0,
        speed_lock:     1'b0,
        motion_speed:   START_SPEED,
        repeat_count:   '0,
        repeats_needed: START_REPEATS
    };

endpackage

// ----- rtl/kmm_step.sv -----
// Combinational update for one key event: next mapper state and the report.
// Depends on kmm_pkg.
module kmm_step
    import kmm_pkg::*;
#(
    parameter int MAX_MOTION_SPEED = MAX_MOTION_SPEED_DEF
) (
    input  t_kmm_state              i_state,
    input  t_kmm_in                 i_item,
    input  logic [WHEEL_STEP_W-1:0] i_wheel_step,
    output t_kmm_state              o_state,
    output t_kmm_out                o_result
);

    localparam logic [SPEED_W:0] MaxSpeed = (SPEED_W+1)'(MAX_MOTION_SPEED);

    t_kmm_state          st;
    t_kmm_out            res;
    logic                early;
    logic [SPEED_W:0]    speed_dbl;
    logic [SPEED_W:0]    speed_ext;
    logic [REPEAT_W-1:0] rc_inc;
    logic [WHEEL_STEP_W:0] step_ext;

    assign step_ext = {1'b0, i_wheel_step};

    // Modifier tracking, caps lock toggle, then the combo key decode.
    always_comb begin
        st        = i_state;
        res       = '0;
        early     = 1'b0;
        speed_dbl = '0;
        speed_ext = '0;
        rc_inc    = '0;
        if (i_item.is_key_event) begin
            case (i_item.key_code)
                KC_LCTRL: begin
                    st.ctrl_held = (i_item.key_action != KV_RELEASE);
                    if (st.speed_lock) begin
                        early         = 1'b1;
                        res.swallowed = 1'b1;
                    end
                end
                KC_LALT: begin
                    st.alt_held = (i_item.key_action != KV_RELEASE);
                    if (st.speed_lock) begin
                        early         = 1'b1;
                        res.swallowed = 1'b1;
                    end
                end
                KC_CAPS: begin
                    if (i_item.key_action == KV_PRESS) begin
                        st.speed_lock = ~st.speed_lock;
                    end
                end
                default: ;
            endcase

            if (!early && st.ctrl_held && st.alt_held) begin
                res.swallowed = 1'b1;
                case (i_item.key_code)
                    KC_P, KC_N, KC_B, KC_F: begin
                        // Speed ramp: reset on press, double after runs of repeats, both only while speed lock is off.
                        case (i_item.key_action)
                            KV_RELEASE: begin
                                st.repeat_count = '0;
                            end
                            KV_PRESS: begin
                                st.repeat_count = '0;
                                if (!st.speed_lock) begin
                                    st.motion_speed   = START_SPEED;
                                    st.repeats_needed = START_REPEATS;
                                end
                            end
                            KV_REPEAT: begin
                                if (!st.speed_lock) begin
                                    rc_inc = st.repeat_count + REPEAT_W'(1);
                                    st.repeat_count = rc_inc;
                                    if (rc_inc >= st.repeats_needed) begin
                                        speed_dbl = {st.motion_speed, 1'b0};
                                        if ({1'b0, st.motion_speed} < MaxSpeed) begin
                                            st.motion_speed = (speed_dbl > MaxSpeed)
                                                ? MaxSpeed[SPEED_W-1:0]
                                                : speed_dbl[SPEED_W-1:0];
                                            st.repeats_needed =
                                                st.repeats_needed + REPEATS_STEP;
                                        end
                                        st.repeat_count = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                        speed_ext       = {1'b0, st.motion_speed};
                        res.report_kind = RK_MOTION;
                        if (i_item.key_code == KC_P) begin
                            res.delta_y = -$signed(speed_ext);
                        end else if (i_item.key_code == KC_N) begin
                            res.delta_y = $signed(speed_ext);
                        end else if (i_item.key_code == KC_B) begin
                            res.delta_x = -$signed(speed_ext);
                        end else begin
                            res.delta_x = $signed(speed_ext);
                        end
                    end
                    KC_V: begin
                        res.report_kind = RK_WHEEL;
                        res.wheel_delta = -$signed(step_ext);
                    end
                    KC_U: begin
                        res.report_kind = RK_WHEEL;
                        res.wheel_delta = $signed(step_ext);
                    end
                    KC_SPACE: begin
                        res.report_kind  = RK_LEFT;
                        res.button_level = i_item.key_action;
                    end
                    KC_M: begin
                        res.report_kind  = RK_RIGHT;
                        res.button_level = i_item.key_action;
                    end
                    default: begin
                        res.swallowed = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

// ----- rtl/keyboard_to_mouse_mapper.sv -----
// Top level of the keyboard-to-mouse mapper: input register, state, result register.
// Depends on kmm_pkg and kmm_step.
//
//  Channel  | Valid       | Ready        | Payload
//  ---------+-------------+--------------+----------------------------
//  events   | i_in_valid  | o_in_ready   | i_in  (t_kmm_in)
//  reports  | o_out_valid | i_out_ready  | o_out (t_kmm_out)
//  config   | i_cfg_valid | o_cfg_ready  | i_cfg_wheel_step (3 bits)
//
// One report beat per event beat; one beat per cycle sustained while i_out_ready stays high.
// The state update happens as a beat moves from the input register to the result register.
// A stalled result register holds its beat; one more event is still taken into the
// input register. Reset is synchronous and active low; wheel step resets to 5.
module keyboard_to_mouse_mapper
    import kmm_pkg::*;
#(
    parameter int MAX_MOTION_SPEED = MAX_MOTION_SPEED_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_kmm_in                 i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_kmm_out                o_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [WHEEL_STEP_W-1:0] i_cfg_wheel_step
);

    logic                    r_in_valid;
    t_kmm_in                 r_in;
    logic                    r_out_valid;
    t_kmm_out                r_out;
    t_kmm_state              r_state;
    logic [WHEEL_STEP_W-1:0] r_wheel_step;

    t_kmm_state n_state;
    t_kmm_out   n_out;
    logic       advance;

    // A beat leaves the input register when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    kmm_step #(
        .MAX_MOTION_SPEED(MAX_MOTION_SPEED)
    ) u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_wheel_step(r_wheel_step),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register and mapper state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= KMM_STATE_RESET;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Wheel step register; a zero write stores the minimum step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_step <= WHEEL_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wheel_step <= (i_cfg_wheel_step == '0) ? WHEEL_STEP_MIN : i_cfg_wheel_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The speed stays between the start value and the cap.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.motion_speed >= START_SPEED) &&
        (int'(r_state.motion_speed) <= MAX_MOTION_SPEED))
        else $error("motion speed out of range");

    // The repeat threshold only moves in steps of two from one, so it stays odd.
    a_repeats_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.repeats_needed[0])
        else $error("repeat threshold lost its odd value");

    // A beat stuck in the input register means the result register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> (r_out_valid && !i_out_ready))
        else $error("input beat held without an output stall");

    // Only motion reports carry motion deltas.
    a_motion_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.report_kind != RK_MOTION)) |->
        ((r_out.delta_x == '0) && (r_out.delta_y == '0)))
        else $error("motion delta on a non-motion report");

endmodule
